@@ rtl/depth_background_bounds_unit_assert.svh @@
// Assertion macros for the depth background bounds unit.
// Needs clk_i and rst_ni in the including scope.
`ifndef DEPTH_BACKGROUND_BOUNDS_UNIT_ASSERT_SVH
`define DEPTH_BACKGROUND_BOUNDS_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define DBB_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dbb assertion failed");
`define DBB_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("dbb assertion failed");
`else
`define DBB_ASSERT_IMPL(lbl, ante, cons)
`define DBB_ASSERT_NEVER(lbl, expr)
`endif
`endif

@@ rtl/dbb_pkg.sv @@
// Shared constants and types of the depth background bounds unit.
// No dependencies.
package dbb_pkg;
  localparam int unsigned PIXELS     = 307200;
  localparam int unsigned ADDR_W     = $clog2(PIXELS);
  localparam int unsigned DEPTH_W    = 16;
  localparam int unsigned DEPTH_BITS = 16;
  localparam int unsigned SUM_W      = 22;
  localparam int unsigned SQ_W       = 39;
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned OUT_W      = 19;
  localparam int unsigned DIV_W      = 46;
  localparam int unsigned DVSR_W     = 2 * CNT_W;
  localparam int unsigned VAR_W      = 32;
  localparam int unsigned ROOT_W     = VAR_W / 2;
  localparam int unsigned MEAN_W     = 16;
  localparam logic [CNT_W-1:0]  COUNT_MAX     = '1;
  localparam logic [CNT_W-1:0]  FRAMES_RESET  = 6'd31;
  localparam logic [ADDR_W-1:0] LAST_ADDR     = ADDR_W'(PIXELS - 1);

  typedef struct packed {
    logic [ADDR_W-1:0]  pixel;
    logic [DEPTH_W-1:0] depth;
    logic               valid;
    logic               fend;
    logic               final_frame;
  } req_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [SQ_W-1:0]  sq;
    logic [CNT_W-1:0] cnt;
  } entry_t;
endpackage

@@ rtl/dbb_front.sv @@
// Front end: accepts samples, tracks raster position and frame count.
// Depends on dbb_pkg.
module dbb_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [5:0]          cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [15:0]         depth_mm_i,
  input  logic                depth_valid_i,
  input  logic                frame_end_i,
  input  logic                clr_done_i,
  input  logic                q_full_i,
  output logic                push_o,
  output dbb_pkg::req_t       push_data_o
);
  import dbb_pkg::*;

  logic [CNT_W-1:0]  frames_cfg_q;
  logic [CNT_W-1:0]  frames_done_q, frames_done_d;
  logic [ADDR_W-1:0] pos_q, pos_d;
  logic              finished_q, finished_d;
  logic              accept;
  logic              final_frame;
  logic [CNT_W:0]    target;

  assign in_stall_o = !clr_done_i || q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign target     = (frames_cfg_q == '0) ? (CNT_W+1)'(1) : {1'b0, frames_cfg_q};
  assign final_frame = ({1'b0, frames_done_q} + (CNT_W+1)'(1)) >= target;

  assign push_o = accept && !finished_q;
  always_comb begin
    push_data_o.pixel       = pos_q;
    push_data_o.depth       = DEPTH_W'(depth_mm_i[DEPTH_BITS-1:0]);
    push_data_o.valid       = depth_valid_i;
    push_data_o.fend        = frame_end_i;
    push_data_o.final_frame = final_frame;
  end

  always_comb begin
    pos_d         = pos_q;
    frames_done_d = frames_done_q;
    finished_d    = finished_q;
    if (push_o) begin
      if (frame_end_i) begin
        pos_d = '0;
        if (frames_done_q != COUNT_MAX) frames_done_d = frames_done_q + CNT_W'(1);
        if (final_frame) finished_d = 1'b1;
      end else begin
        pos_d = (pos_q == LAST_ADDR) ? '0 : pos_q + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_cfg_q  <= FRAMES_RESET;
      frames_done_q <= '0;
      pos_q         <= '0;
      finished_q    <= 1'b0;
    end else begin
      if (cfg_we_i) frames_cfg_q <= cfg_data_i;
      frames_done_q <= frames_done_d;
      pos_q         <= pos_d;
      finished_q    <= finished_d;
    end
  end
endmodule

@@ rtl/dbb_queue.sv @@
// Two-entry request queue between front and back end.
// Depends on dbb_pkg.
module dbb_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dbb_pkg::req_t push_data_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          pop_i,
  output dbb_pkg::req_t pop_data_o
);
  import dbb_pkg::*;

  req_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o     = cnt_q == 2'd2;
  assign valid_o    = cnt_q != 2'd0;
  assign pop_data_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end
endmodule

@@ rtl/dbb_divider.sv @@
// Iterative restoring divider, two quotient bits per cycle.
// Depends on dbb_pkg.
module dbb_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [dbb_pkg::DIV_W-1:0]   dividend_i,
  input  logic [dbb_pkg::DVSR_W-1:0]  divisor_i,
  output logic                        done_o,
  output logic [dbb_pkg::DIV_W-1:0]   quotient_o
);
  import dbb_pkg::*;

  localparam int unsigned STEPS = DIV_W / 2;
  localparam int unsigned CW    = $clog2(STEPS);

  logic [DIV_W-1:0]  quo_q, quo_d;
  logic [DVSR_W:0]   rem_q, rem_d;
  logic [DVSR_W-1:0] dvsr_q;
  logic [CW-1:0]     cnt_q;
  logic              busy_q, done_q;

  always_comb begin
    logic [DVSR_W:0] r;
    logic [DIV_W-1:0] qv;
    r  = rem_q;
    qv = quo_q;
    for (int i = 0; i < 2; i++) begin
      r  = {r[DVSR_W-1:0], qv[DIV_W-1]};
      qv = {qv[DIV_W-2:0], 1'b0};
      if (r >= {1'b0, dvsr_q}) begin
        r     = r - {1'b0, dvsr_q};
        qv[0] = 1'b1;
      end
    end
    rem_d = r;
    quo_d = qv;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q  <= dividend_i;
      rem_q  <= '0;
      dvsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end
endmodule

@@ rtl/dbb_back.sv @@
// Back end: per-pixel statistics store, update, bounds computation.
// Depends on dbb_pkg and dbb_divider.
module dbb_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_valid_i,
  input  dbb_pkg::req_t                  q_data_i,
  output logic                           pop_o,
  output logic                           clr_done_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [dbb_pkg::ADDR_W-1:0]     pixel_index_o,
  output logic signed [dbb_pkg::OUT_W-1:0] upper_bound_mm_o,
  output logic signed [dbb_pkg::OUT_W-1:0] lower_bound_mm_o,
  output logic                           bounds_valid_o,
  output logic                           last_pixel_o
);
  import dbb_pkg::*;

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b00000001,
    ST_IDLE  = 8'b00000010,
    ST_READ  = 8'b00000100,
    ST_MUL   = 8'b00001000,
    ST_SUB   = 8'b00010000,
    ST_DIV   = 8'b00100000,
    ST_SQRT  = 8'b01000000,
    ST_OUT   = 8'b10000000
  } state_e;

  state_e state_q, state_d;

  entry_t mem [PIXELS];
  entry_t rd_q, upd;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr;
  entry_t            mem_wdata;
  logic [ADDR_W-1:0] clr_addr_q;

  req_t              req_q;
  logic [CNT_W-1:0]  n_q;
  logic [SUM_W-1:0]  s_q;
  logic [SQ_W-1:0]   sq_q;
  logic [SQ_W+CNT_W-1:0] p1_q;
  logic [2*SUM_W-1:0]    p2_q;
  logic [DVSR_W-1:0]     nn_q;

  logic              div_start;
  logic              var_done, mean_done;
  logic [DIV_W-1:0]  var_quo, mean_quo;
  logic [MEAN_W-1:0] mean_q;

  logic [VAR_W-1:0]   rad_q;
  logic [ROOT_W:0]    rem_q;
  logic [ROOT_W-1:0]  root_q;
  logic [$clog2(ROOT_W)-1:0] sq_cnt_q;
  logic [ROOT_W+2:0]  rem_n, trial;
  logic               rt_ge;

  logic signed [OUT_W-1:0] res_up_q, res_lo_q;
  logic                    res_bv_q;
  logic                    out_free;

  // stats update for the request whose entry was just read
  always_comb begin
    upd = rd_q;
    if (req_q.valid && rd_q.cnt != COUNT_MAX) begin
      upd.sum = rd_q.sum + SUM_W'(req_q.depth);
      upd.sq  = rd_q.sq + SQ_W'(req_q.depth) * SQ_W'(req_q.depth);
      upd.cnt = rd_q.cnt + CNT_W'(1);
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = req_q.pixel;
    mem_wdata = upd;
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_q;
      mem_wdata = '0;
    end else if (state_q == ST_READ) begin
      mem_we = 1'b1;
    end
  end

  assign mem_re     = (state_q == ST_IDLE) && q_valid_i;
  assign pop_o      = mem_re;
  assign clr_done_o = state_q != ST_CLEAR;
  assign div_start  = state_q == ST_SUB;
  assign out_free   = !out_valid_o || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_q <= mem[q_data_i.pixel];
  end

  dbb_divider u_var_div (
    .clk_i, .rst_ni,
    .start_i    (div_start),
    .dividend_i (DIV_W'(p1_q) - DIV_W'(p2_q)),
    .divisor_i  (nn_q),
    .done_o     (var_done),
    .quotient_o (var_quo)
  );

  dbb_divider u_mean_div (
    .clk_i, .rst_ni,
    .start_i    (div_start),
    .dividend_i (DIV_W'(s_q)),
    .divisor_i  (DVSR_W'(n_q)),
    .done_o     (mean_done),
    .quotient_o (mean_quo)
  );

  // one root bit per cycle
  assign rem_n = {rem_q, rad_q[VAR_W-1 -: 2]};
  assign trial = (ROOT_W+3)'({root_q, 2'b01});
  assign rt_ge = rem_n >= trial;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_addr_q == LAST_ADDR) state_d = ST_IDLE;
      ST_IDLE:  if (q_valid_i) state_d = ST_READ;
      ST_READ: begin
        if (!req_q.final_frame)  state_d = ST_IDLE;
        else if (upd.cnt == '0)  state_d = ST_OUT;
        else                     state_d = ST_MUL;
      end
      ST_MUL:  state_d = ST_SUB;
      ST_SUB:  state_d = ST_DIV;
      ST_DIV:  if (var_done && mean_done) state_d = ST_SQRT;
      ST_SQRT: if (sq_cnt_q == '1) state_d = ST_OUT;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) req_q <= q_data_i;
    if (state_q == ST_READ) begin
      n_q      <= upd.cnt;
      s_q      <= upd.sum;
      sq_q     <= upd.sq;
      res_up_q <= '0;
      res_lo_q <= '0;
      res_bv_q <= 1'b0;
    end
    if (state_q == ST_MUL) begin
      p1_q <= (SQ_W+CNT_W)'(n_q) * (SQ_W+CNT_W)'(sq_q);
      p2_q <= (2*SUM_W)'(s_q) * (2*SUM_W)'(s_q);
      nn_q <= DVSR_W'(n_q) * DVSR_W'(n_q);
    end
    if (state_q == ST_DIV && var_done) begin
      rad_q    <= var_quo[VAR_W-1:0];
      rem_q    <= '0;
      root_q   <= '0;
      mean_q   <= mean_quo[MEAN_W-1:0];
    end
    if (state_q == ST_SQRT) begin
      rad_q  <= {rad_q[VAR_W-3:0], 2'b00};
      rem_q  <= rt_ge ? (ROOT_W+1)'(rem_n - trial) : (ROOT_W+1)'(rem_n);
      root_q <= {root_q[ROOT_W-2:0], rt_ge};
      if (sq_cnt_q == '1) begin
        res_up_q <= OUT_W'(mean_q) + OUT_W'({root_q[ROOT_W-2:0], rt_ge, 1'b0});
        res_lo_q <= OUT_W'(mean_q) - OUT_W'({root_q[ROOT_W-2:0], rt_ge, 1'b0});
        res_bv_q <= 1'b1;
      end
    end
    if (state_q == ST_OUT && out_free) begin
      pixel_index_o    <= req_q.pixel;
      upper_bound_mm_o <= res_up_q;
      lower_bound_mm_o <= res_lo_q;
      bounds_valid_o   <= res_bv_q;
      last_pixel_o     <= req_q.fend;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      sq_cnt_q    <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_addr_q <= clr_addr_q + ADDR_W'(1);
      if (state_q == ST_SQRT) sq_cnt_q <= sq_cnt_q + $clog2(ROOT_W)'(1);
      else                    sq_cnt_q <= '0;
      if (state_q == ST_OUT && out_free) out_valid_o <= 1'b1;
      else if (!out_stall_i)             out_valid_o <= 1'b0;
    end
  end
endmodule

@@ rtl/depth_background_bounds_unit.sv @@
// Per-pixel depth background bounds: mean +/- 2 sigma over learned frames.
// Learning frames: each request gets a stats read, then a write-back; no result.
// Final frame: stats read, multiply, subtract, divide (variance and mean), square root
// and output; a pixel without samples goes from read to output. One request at a time.
// After reset a clearing pass over all 307200 entries zeroes the stats; input stalls meanwhile.
// Depends on dbb_pkg, dbb_front, dbb_queue (2 deep), dbb_back and the assertion header.
`include "depth_background_bounds_unit_assert.svh"
module depth_background_bounds_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [5:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [15:0]        depth_mm_i,
  input  logic               depth_valid_i,
  input  logic               frame_end_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [18:0]        pixel_index_o,
  output logic signed [18:0] upper_bound_mm_o,
  output logic signed [18:0] lower_bound_mm_o,
  output logic               bounds_valid_o,
  output logic               last_pixel_o
);
  import dbb_pkg::*;

  logic clr_done, q_full, push, q_valid, pop;
  req_t push_data, pop_data;

  dbb_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i, .in_valid_i, .in_stall_o,
    .depth_mm_i, .depth_valid_i, .frame_end_i,
    .clr_done_i  (clr_done),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  dbb_queue u_queue (
    .clk_i, .rst_ni,
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .pop_i       (pop),
    .pop_data_o  (pop_data)
  );

  dbb_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i   (q_valid),
    .q_data_i    (pop_data),
    .pop_o       (pop),
    .clr_done_o  (clr_done),
    .out_valid_o, .out_stall_i, .pixel_index_o, .upper_bound_mm_o,
    .lower_bound_mm_o, .bounds_valid_o, .last_pixel_o
  );

  `DBB_ASSERT_IMPL(a_empty_zero, out_valid_o && !bounds_valid_o, upper_bound_mm_o == '0 && lower_bound_mm_o == '0)
  `DBB_ASSERT_IMPL(a_order, out_valid_o, lower_bound_mm_o <= upper_bound_mm_o)
  `DBB_ASSERT_IMPL(a_spread, out_valid_o, upper_bound_mm_o[1:0] == lower_bound_mm_o[1:0])
  `DBB_ASSERT_NEVER(a_clear_stall, !clr_done && !in_stall_o)
endmodule
